>>> rtl/core/lec_pkg.sv
// lec_pkg: shared constants, types and control structs of the lms echo canceller
// depends on nothing; imported by lec_mul, lec_seq and lms_echo_canceller_core
`timescale 1ns / 1ps

package lec_pkg;

    localparam int TAPS     = 128;
    localparam int LOG_TAPS = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int IDX_W    = LOG_TAPS;

    localparam int X_W      = 16;
    localparam int W_W      = 32;
    localparam int MU_W     = 32;

    // accumulator holds the exact sum of TAPS products of 16 x 31 bits
    localparam int ACC_W    = (LOG_TAPS < 4) ? 52 : 48 + LOG_TAPS;
    // error with 8 fraction bits and its magnitude
    localparam int E_W      = ACC_W - 18;
    localparam int EM_W     = E_W - 1;

    // shared multiplier: signed 33 x 33
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;

    // step times error magnitude, split for the per-tap products
    localparam int M_W      = 58;
    localparam int MLO_W    = 27;
    localparam int MHI_W    = M_W - MLO_W;
    localparam int PHI_W    = MHI_W + X_W;

    localparam logic signed [W_W+1:0] W_LIMIT   = (W_W+2)'(64'sd536870912);
    localparam logic [31:0]           DELTA_CAP = 32'h8000_0000;
    localparam int                    RND_HALF  = 524288;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIR,
        OP_ERR,
        OP_MU_LO,
        OP_MU_HI,
        OP_UPD_HI,
        OP_UPD_LO
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIR,
        ST_ERR,
        ST_WAIT,
        ST_MLO,
        ST_MHI,
        ST_GAP,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        t_idx tap;
        t_idx xaddr;
        logic clr;
        logic load_x;
        logic load_out;
    } t_seq_ctl;

    typedef struct packed {
        t_op  op;
        t_idx tap;
    } t_stage;

endpackage

>>> rtl/core/lec_ifs.sv
// lec_ifs: valid/ready channel interfaces for the sample words in and out
// no dependencies
`timescale 1ns / 1ps

interface lec_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mic_sample;
    logic signed [15:0] ref_sample;
    logic               block_last;

    modport source (output valid, output mic_sample, output ref_sample,
                    output block_last, input ready);
    modport sink   (input valid, input mic_sample, input ref_sample,
                    input block_last, output ready);
endinterface

interface lec_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cleaned_sample;
    logic               block_last_out;

    modport source (output valid, output cleaned_sample, output block_last_out,
                    input ready);
    modport sink   (input valid, input cleaned_sample, input block_last_out,
                    output ready);
endinterface

>>> rtl/core/lec_ram.sv
// lec_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lec_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lec_mul.sv
// lec_mul: the shared signed 33 x 33 multiplier with a registered product
// depends on lec_pkg
`timescale 1ns / 1ps

module lec_mul
    import lec_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/lec_seq.sv
// lec_seq: sequencer that walks the taps for the filter pass and the update pass
// depends on lec_pkg
`timescale 1ns / 1ps

module lec_seq
    import lec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    output logic     o_in_ready,
    output t_seq_ctl o_ctl
);

    localparam t_idx TAPS_LAST = IDX_W'(TAPS - 1);

    t_state r_state, n_state;
    t_idx   r_cnt,   n_cnt;
    t_idx   r_head,  n_head;
    t_idx   r_xp,    n_xp;
    logic   r_half,  n_half;

    function automatic t_idx idx_inc(input t_idx v);
        return (v == TAPS_LAST) ? '0 : v + 1'b1;
    endfunction

    function automatic t_idx idx_dec(input t_idx v);
        return (v == '0) ? TAPS_LAST : v - 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_head  <= '0;
            r_xp    <= '0;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_xp    <= n_xp;
            r_half  <= n_half;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_cnt == TAPS_LAST) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_FIR;
            ST_FIR:   if (r_cnt == TAPS_LAST) n_state = ST_ERR;
            ST_ERR:   n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_MLO;
            ST_MLO:   n_state = ST_MHI;
            ST_MHI:   n_state = ST_GAP;
            ST_GAP:   n_state = ST_UPD;
            ST_UPD:   if (r_half && r_cnt == TAPS_LAST) n_state = ST_OUT;
            ST_OUT:   if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // tap counter and delay line pointers
    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_xp   = r_xp;
        n_half = r_half;
        case (r_state)
            ST_CLEAR: n_cnt = idx_inc(r_cnt);
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_head = idx_inc(r_head);
                    n_xp   = idx_inc(r_head);
                    n_cnt  = '0;
                end
            end
            ST_FIR: begin
                n_cnt = idx_inc(r_cnt);
                n_xp  = (r_cnt == TAPS_LAST) ? r_head : idx_dec(r_xp);
            end
            ST_UPD: begin
                n_half = ~r_half;
                if (r_half) begin
                    n_cnt = idx_inc(r_cnt);
                    n_xp  = idx_dec(r_xp);
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl.op       = OP_NONE;
        o_ctl.tap      = r_cnt;
        o_ctl.xaddr    = r_xp;
        o_ctl.clr      = 1'b0;
        o_ctl.load_x   = 1'b0;
        o_ctl.load_out = 1'b0;
        case (r_state)
            ST_CLEAR: o_ctl.clr = 1'b1;
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.xaddr  = idx_inc(r_head);
                o_ctl.load_x = i_in_valid;
            end
            ST_FIR:  o_ctl.op = OP_FIR;
            ST_ERR:  o_ctl.op = OP_ERR;
            ST_MLO:  o_ctl.op = OP_MU_LO;
            ST_MHI:  o_ctl.op = OP_MU_HI;
            ST_UPD:  o_ctl.op = r_half ? OP_UPD_LO : OP_UPD_HI;
            ST_OUT:  o_ctl.load_out = i_out_free;
            default: o_ctl.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/core/lms_echo_canceller_core.sv
// lms_echo_canceller_core: top level, datapath around the shared multiplier
// depends on lec_pkg, lec_ifs, lec_ram, lec_mul, lec_seq
`timescale 1ns / 1ps

// usage:
// i_in carries one word per sample pair (mic_sample, ref_sample, block_last);
// o_out carries one word per input (cleaned_sample, block_last_out).
// both are valid/ready channels; a word moves when valid and ready are high.
// i_cfg_we / i_cfg_wdata write the step size; write it only while idle.
// one multiplier does all products: one per tap for the filter pass,
// two per tap for the weight update (two partial products per tap), with
// the error and step scaling in between. the next input is taken only
// once the previous one is processed and its result loaded for output.
// after reset a clearing pass over all taps zeroes the delay line and the
// weights; i_in.ready stays low during it.
// the result sits in an output register; if the receiver stalls, the next
// input is still taken and processed, and only its final load waits for
// the output register to drain.

module lms_echo_canceller_core
    import lec_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lec_in_if.sink       i_in,
    lec_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);

    t_seq_ctl ctl;
    logic     in_ready;
    logic     out_free;
    logic     accept;

    t_stage r_s1, r_s2, r_s3;

    logic [MU_W-1:0]           r_mu;
    logic signed [X_W-1:0]     r_mic;
    logic                      r_last;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [E_W-1:0]     r_e8;
    logic [EM_W-1:0]           r_emag;
    logic                      r_eneg;
    logic [63:0]               r_mlo;
    logic                      r_msat;
    logic [M_W-1:0]            r_mval;
    logic [PHI_W-1:0]          r_phi;
    logic signed [W_W-1:0]     r_wcap;
    logic [X_W-1:0]            r_xmag;
    logic                      r_xneg;
    logic signed [W_W:0]       r_delta;

    logic                      r_out_valid;
    logic signed [15:0]        r_out_sample;
    logic                      r_out_last;

    logic [X_W-1:0]            x_rd;
    logic [W_W-1:0]            w_rd;
    logic signed [X_W-1:0]     x_s;
    logic [X_W-1:0]            xmag;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      xw_we;
    t_idx                      xw_addr;
    logic [X_W-1:0]            xw_data;
    logic                      ww_we;
    t_idx                      ww_addr;
    logic [W_W-1:0]            ww_data;

    logic signed [ACC_W:0]     acc_rnd;
    logic signed [ACC_W-20:0]  fir_est;
    logic signed [E_W-1:0]     mic8;
    logic signed [E_W-1:0]     e8;
    logic signed [E_W-1:0]     e8_neg;

    logic [64:0]               m_sum;
    logic                      m_sat;

    logic [PHI_W:0]            dm;
    logic                      d_cap;
    logic [31:0]               dmag;
    logic signed [W_W:0]       delta;

    logic signed [W_W+1:0]     wsum;
    logic signed [W_W-1:0]     wnew;

    logic signed [E_W-1:0]     q_bias;
    logic signed [E_W-1:0]     q_full;
    logic signed [15:0]        q_sat;

    lec_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    assign accept     = i_in.valid & in_ready;
    assign i_in.ready = in_ready;
    assign out_free   = ~r_out_valid | o_out.ready;

    // delay line storage, newest sample at the head pointer
    assign xw_we   = ctl.clr | ctl.load_x;
    assign xw_addr = ctl.clr ? ctl.tap : ctl.xaddr;
    assign xw_data = ctl.clr ? '0 : i_in.ref_sample;

    lec_ram #(.DEPTH(TAPS), .WIDTH(X_W)) u_xram (
        .i_clk   (i_clk),
        .i_we    (xw_we),
        .i_waddr (xw_addr),
        .i_wdata (xw_data),
        .i_raddr (ctl.xaddr),
        .o_rdata (x_rd)
    );

    assign ww_we   = ctl.clr | (r_s3.op == OP_UPD_LO);
    assign ww_addr = ctl.clr ? ctl.tap : r_s3.tap;
    assign ww_data = ctl.clr ? '0 : wnew;

    lec_ram #(.DEPTH(TAPS), .WIDTH(W_W)) u_wram (
        .i_clk   (i_clk),
        .i_we    (ww_we),
        .i_waddr (ww_addr),
        .i_wdata (ww_data),
        .i_raddr (ctl.tap),
        .o_rdata (w_rd)
    );

    // stage 1: operand select
    assign x_s  = $signed(x_rd);
    assign xmag = x_s[X_W-1] ? X_W'(-x_s) : X_W'(x_s);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_s1.op)
            OP_FIR: begin
                mul_a = MUL_W'(x_s);
                mul_b = MUL_W'($signed(w_rd));
            end
            OP_MU_LO: begin
                mul_a = $signed({1'b0, r_mu});
                mul_b = $signed({1'b0, r_emag[31:0]});
            end
            OP_MU_HI: begin
                mul_a = $signed({1'b0, r_mu});
                mul_b = $signed(MUL_W'(r_emag[EM_W-1:32]));
            end
            OP_UPD_HI: begin
                mul_a = $signed(MUL_W'(r_mval[M_W-1:MLO_W]));
                mul_b = $signed(MUL_W'(xmag));
            end
            OP_UPD_LO: begin
                mul_a = $signed(MUL_W'(r_mval[MLO_W-1:0]));
                mul_b = $signed(MUL_W'(xmag));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lec_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // stage 2: error with round to nearest, ties up
    assign acc_rnd = (ACC_W+1)'(r_acc) + (ACC_W+1)'(RND_HALF);
    assign fir_est = acc_rnd[ACC_W:20];
    assign mic8    = E_W'(r_mic) <<< 8;
    assign e8      = mic8 - E_W'(fir_est);
    assign e8_neg  = -e8;

    // step times error magnitude, saturated at 2^58 and above
    assign m_sum = 65'({prod[25:0], 32'b0}) + 65'(r_mlo);
    assign m_sat = (|prod[PROD_W-1:26]) | (|m_sum[64:M_W]);

    // weight delta magnitude, capped
    assign dm    = (PHI_W+1)'(r_phi) + (PHI_W+1)'(prod[MLO_W+X_W-1:MLO_W]);
    assign d_cap = (r_msat && r_xmag != '0) || (dm > (PHI_W+1)'(DELTA_CAP));
    assign dmag  = d_cap ? DELTA_CAP : dm[31:0];
    assign delta = (r_eneg ^ r_xneg) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

    // stage 3: weight add and clamp
    assign wsum = (W_W+2)'(r_wcap) + (W_W+2)'(r_delta);
    always_comb begin
        if (wsum > W_LIMIT) begin
            wnew = W_W'(W_LIMIT);
        end else if (wsum < -W_LIMIT) begin
            wnew = W_W'(-W_LIMIT);
        end else begin
            wnew = W_W'(wsum);
        end
    end

    // output: truncate toward zero, saturate to 16 bits
    assign q_bias = r_e8 + (r_e8[E_W-1] ? E_W'(255) : E_W'(0));
    assign q_full = q_bias >>> 8;
    always_comb begin
        if (q_full > E_W'(32767)) begin
            q_sat = 16'sh7fff;
        end else if (q_full < -E_W'(32768)) begin
            q_sat = -16'sh8000;
        end else begin
            q_sat = 16'(q_full);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '{op: OP_NONE, tap: '0};
            r_s2        <= '{op: OP_NONE, tap: '0};
            r_s3        <= '{op: OP_NONE, tap: '0};
            r_mu        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= '{op: ctl.op, tap: ctl.tap};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            if (i_cfg_we) begin
                r_mu <= i_cfg_wdata;
            end
            if (ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mic  <= i_in.mic_sample;
            r_last <= i_in.block_last;
            r_acc  <= '0;
        end
        if (r_s1.op == OP_UPD_LO) begin
            r_wcap <= $signed(w_rd);
            r_xmag <= xmag;
            r_xneg <= x_s[X_W-1];
        end
        case (r_s2.op)
            OP_FIR: r_acc <= r_acc + ACC_W'(prod);
            OP_ERR: begin
                r_e8   <= e8;
                r_eneg <= e8[E_W-1];
                r_emag <= e8[E_W-1] ? EM_W'(e8_neg) : EM_W'(e8);
            end
            OP_MU_LO: r_mlo <= prod[63:0];
            OP_MU_HI: begin
                r_msat <= m_sat;
                r_mval <= m_sum[M_W-1:0];
            end
            OP_UPD_HI: r_phi <= prod[PHI_W-1:0];
            OP_UPD_LO: r_delta <= delta;
            default: begin
            end
        endcase
        if (ctl.load_out) begin
            r_out_sample <= q_sat;
            r_out_last   <= r_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cleaned_sample = r_out_sample;
    assign o_out.block_last_out = r_out_last;

endmodule
